[hw/rtl/mtmf_pkg.sv]
// shared constants for the multichannel trimmed-mean filter
// no dependencies; used by mtmf_trim, mtmf_div3 and the top module
`default_nettype none

package mtmf_pkg;

    // width of the channel field on the input beat
    localparam int CHAN_W = 2;

    // past samples kept per channel; window is these plus the new sample
    localparam int HIST_LEN = 4;
    localparam int WIN_LEN  = HIST_LEN + 1;

    // divide by three: x = xh * 2^16 + xl, and 2^16 = 3 * 21845 + 1
    localparam int DIV3_SPLIT_W = 16;
    localparam int DIV3_HI_MUL  = 21845;
    localparam int DIV3_MUL_W   = 15;

endpackage : mtmf_pkg

`default_nettype wire

[hw/rtl/mtmf_hist_ram.sv]
// per-channel history memory: one row holds a channel's whole history
// registered read, row valid bits for the zero reset, write-to-read forwarding
// depends on nothing outside this file
`default_nettype none

module mtmf_hist_ram #(
    parameter int ROWS   = 4,
    parameter int IDX_W  = 2,
    parameter int DATA_W = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] hist_mem [0:ROWS-1];
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;
    logic              fwd_hit_next;
    logic              hit_valid_reg;
    logic [ROWS-1:0]   row_valid_reg;
    logic [ROWS-1:0]   row_valid_next;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg    <= hist_mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // row valid bits: a row never written reads as zero
    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
    end

    // same row written in the read cycle: take the write beat instead
    assign fwd_hit_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            fwd_hit_reg   <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            if (rd_en)
            begin
                fwd_hit_reg   <= fwd_hit_next;
                hit_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // read data select
    always_comb
    begin
        priority if (fwd_hit_reg)
        begin
            rd_data = fwd_data_reg;
        end
        else if (hit_valid_reg)
        begin
            rd_data = rdata_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

`ifndef ASSERT_OFF
    // a read that collides with a write returns the written row
    a_fwd_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en && (rd_addr == wr_addr)) |=> (rd_data == $past(wr_data)))
        else $error("hist ram: collision read did not return write data");

    // without a read the read data holds
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !rd_en |=> $stable(rd_data))
        else $error("hist ram: read data changed without a read");
`endif

endmodule : mtmf_hist_ram

`default_nettype wire

[hw/rtl/mtmf_trim.sv]
// trim stage: drops one largest and one smallest of five, sums the middle three
// uses mtmf_pkg for the history length
`default_nettype none

module mtmf_trim #(
    parameter int W = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [mtmf_pkg::HIST_LEN*W-1:0] row,
    input  wire logic [W-1:0]                   sample,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [W+1:0]                   mid_sum
);

    localparam int SUM_W = W + 2;
    localparam int TOT_W = W + 3;

    logic [W-1:0]     win [0:mtmf_pkg::WIN_LEN-1];
    logic [W-1:0]     hi_val;
    logic [W-1:0]     lo_val;
    logic [TOT_W-1:0] total;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_reg;
    logic             valid_reg;

    // window: oldest first, new sample last
    always_comb
    begin
        for (int i = 0; i < mtmf_pkg::HIST_LEN; i++)
        begin
            win[i] = row[i*W +: W];
        end
        win[mtmf_pkg::HIST_LEN] = sample;
    end

    // max, min and total of the window
    always_comb
    begin
        hi_val = win[0];
        lo_val = win[0];
        total  = '0;
        for (int i = 0; i < mtmf_pkg::WIN_LEN; i++)
        begin
            total = total + TOT_W'(win[i]);
            if (win[i] > hi_val)
            begin
                hi_val = win[i];
            end
            if (win[i] < lo_val)
            begin
                lo_val = win[i];
            end
        end
        sum_next = SUM_W'(total - TOT_W'(hi_val) - TOT_W'(lo_val));
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = valid_reg;
    assign mid_sum   = sum_reg;

`ifndef ASSERT_OFF
    // a stalled sum keeps its value
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> (valid_reg && $stable(sum_reg)))
        else $error("trim: stalled sum changed");
`endif

endmodule : mtmf_trim

`default_nettype wire

[hw/rtl/mtmf_div3.sv]
// divide-by-three pipeline: split, two constant multiplies, final add
// uses mtmf_pkg for the split point and the high-part multiplier
`default_nettype none

module mtmf_div3 #(
    parameter int SUM_W = 18,
    parameter int OUT_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [SUM_W-1:0] dividend,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [OUT_W-1:0] quotient
);

    localparam int SPLIT = mtmf_pkg::DIV3_SPLIT_W;
    localparam int HI_W  = (SUM_W > SPLIT) ? SUM_W - SPLIT : 1;
    localparam int XL_W  = (SUM_W < SPLIT) ? SUM_W : SPLIT;
    localparam int Y_W   = ((HI_W > XL_W) ? HI_W : XL_W) + 1;
    localparam int K     = Y_W + 1;
    localparam int PR_W  = Y_W + K;
    localparam int P1_W  = HI_W + mtmf_pkg::DIV3_MUL_W;
    localparam int Q_W   = ((P1_W > Y_W) ? P1_W : Y_W) + 1;
    // ceil(2^K / 3): exact floor(y / 3) for every y below 2^Y_W
    localparam logic [K-1:0] RECIP = K'(((64'd1 << K) + 64'd2) / 64'd3);

    logic            b_valid_reg;
    logic [HI_W-1:0] b_xh_reg;
    logic [Y_W-1:0]  b_y_reg;
    logic [HI_W-1:0] xh_next;
    logic [Y_W-1:0]  y_next;
    logic            c_valid_reg;
    logic [P1_W-1:0] c_p1_reg;
    logic [Y_W-1:0]  c_p2_reg;
    logic [P1_W-1:0] p1_next;
    logic [PR_W-1:0] prod;
    logic [Y_W-1:0]  p2_next;
    logic            o_valid_reg;
    logic [OUT_W-1:0] o_q_reg;
    logic [Q_W-1:0]  q_next;
    logic            out_en;
    logic            c_en;
    logic            b_en;

    // stage enables
    assign out_en   = !o_valid_reg || out_ready;
    assign c_en     = !c_valid_reg || out_en;
    assign b_en     = !b_valid_reg || c_en;
    assign in_ready = b_en;

    // split: x/3 = xh*21845 + (xh + xl)/3
    assign xh_next = HI_W'(dividend >> SPLIT);
    assign y_next  = Y_W'(xh_next) + Y_W'(XL_W'(dividend));

    // constant multiplies
    assign p1_next = P1_W'(b_xh_reg) * P1_W'(mtmf_pkg::DIV3_HI_MUL);
    assign prod    = PR_W'(b_y_reg) * PR_W'(RECIP);
    assign p2_next = Y_W'(prod >> K);

    // final add
    assign q_next = Q_W'(c_p1_reg) + Q_W'(c_p2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_en)
            begin
                b_valid_reg <= in_valid;
            end
            if (c_en)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (out_en)
            begin
                o_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && b_en)
        begin
            b_xh_reg <= xh_next;
            b_y_reg  <= y_next;
        end
        if (b_valid_reg && c_en)
        begin
            c_p1_reg <= p1_next;
            c_p2_reg <= p2_next;
        end
        if (c_valid_reg && out_en)
        begin
            o_q_reg <= OUT_W'(q_next);
        end
    end

    assign out_valid = o_valid_reg;
    assign quotient  = o_q_reg;

`ifndef ASSERT_OFF
    // products wait while the output register is blocked
    a_c_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !out_en) |=> (c_valid_reg && $stable(c_p1_reg) && $stable(c_p2_reg)))
        else $error("div3: stalled products changed");
`endif

endmodule : mtmf_div3

`default_nettype wire

[hw/rtl/multichannel_trimmed_mean_filter.sv]
// Multichannel trimmed-mean filter. Each input beat carries a channel number
// and a sample; the result is the floor of the mean of the middle three of the
// channel's four past samples and the new one, after which the sample enters
// that channel's history. One beat is taken every cycle while the output is
// not held off; an accepted beat passes the history read, trim, split,
// multiply and final add registers, five in flight at most. The history of
// each channel is one memory row read in a single access; a row written in
// the cycle it is read again is forwarded. Rows read as zero until first
// written, so there is no clearing pass after reset. A channel at or above
// CHANNELS returns zero and leaves the history alone.
// depends on mtmf_pkg, mtmf_hist_ram, mtmf_trim and mtmf_div3
`default_nettype none

module multichannel_trimmed_mean_filter #(
    parameter int CHANNELS    = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [mtmf_pkg::CHAN_W-1:0] channel,
    input  wire logic [SAMPLE_BITS-1:0]      sample,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [SAMPLE_BITS-1:0]      filtered
);

    localparam int CHAN_W = mtmf_pkg::CHAN_W;
    localparam int ROWS   = (CHANNELS < (1 << CHAN_W)) ? CHANNELS : (1 << CHAN_W);
    localparam int IDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DATA_W = mtmf_pkg::HIST_LEN * SAMPLE_BITS;
    localparam int SUM_W  = SAMPLE_BITS + 2;

    logic                   s1_valid_reg;
    logic                   s1_inrange_reg;
    logic [IDX_W-1:0]       s1_addr_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                   s1_en;
    logic                   in_range;
    logic                   rd_en;
    logic [DATA_W-1:0]      rd_data;
    logic                   wr_en;
    logic [DATA_W-1:0]      wr_data;
    logic [DATA_W-1:0]      trim_row;
    logic                   trim_in_ready;
    logic                   trim_out_valid;
    logic                   div_in_ready;
    logic [SUM_W-1:0]       mid_sum;

    // channel check and history read on an accepted beat
    assign in_range = ({1'b0, channel} < (CHAN_W + 1)'(ROWS));
    assign s1_en    = !s1_valid_reg || trim_in_ready;
    assign in_ready = s1_en;
    assign rd_en    = in_valid && s1_en && in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_en)
        begin
            s1_inrange_reg <= in_range;
            s1_addr_reg    <= IDX_W'(channel);
            s1_sample_reg  <= sample;
        end
    end

    // shift the new sample in as the newest entry when the beat moves on
    assign wr_en    = s1_valid_reg && trim_in_ready && s1_inrange_reg;
    assign wr_data  = {s1_sample_reg, rd_data[DATA_W-1:SAMPLE_BITS]};
    assign trim_row = s1_inrange_reg ? rd_data : '0;

    mtmf_hist_ram #(
        .ROWS   (ROWS),
        .IDX_W  (IDX_W),
        .DATA_W (DATA_W)
    ) u_hist_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (IDX_W'(channel)),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data)
    );

    mtmf_trim #(
        .W (SAMPLE_BITS)
    ) u_trim (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (trim_in_ready),
        .row       (trim_row),
        .sample    (s1_sample_reg),
        .out_valid (trim_out_valid),
        .out_ready (div_in_ready),
        .mid_sum   (mid_sum)
    );

    mtmf_div3 #(
        .SUM_W (SUM_W),
        .OUT_W (SAMPLE_BITS)
    ) u_div3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trim_out_valid),
        .in_ready  (div_in_ready),
        .dividend  (mid_sum),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quotient  (filtered)
    );

`ifndef ASSERT_OFF
    // a held beat in the read stage must not have its row data overwritten
    a_no_read_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !trim_in_ready) |-> !rd_en)
        else $error("filter: history read while read stage stalled");

    // an out-of-range channel never touches the history
    a_range_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_range) |=> !wr_en)
        else $error("filter: out-of-range beat wrote history");
`endif

endmodule : multichannel_trimmed_mean_filter

`default_nettype wire

[test/multichannel_trimmed_mean_filter_tb.sv]
// testbench for multichannel_trimmed_mean_filter: per-channel history predictor,
// in-order result checking, random idling and a long output hold-off
// depends on mtmf_pkg and the multichannel_trimmed_mean_filter rtl
`timescale 1ns / 100ps

module multichannel_trimmed_mean_filter_tb;

    localparam int CHAN_W         = mtmf_pkg::CHAN_W;
    localparam int HIST_LEN       = mtmf_pkg::HIST_LEN;
    localparam int WIN_LEN        = mtmf_pkg::WIN_LEN;
    localparam int SAMPLE_W       = 16;
    localparam int CHAN_COUNT     = 4;
    localparam int MID_COUNT      = WIN_LEN - 2;
    localparam int IDLE_PCT       = 26;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int BURST_BEATS    = 10;
    localparam int ALT_BEATS      = 20;
    localparam int RANDOM_BEATS   = 930;
    localparam int STALL_BEATS    = 40;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int WATCHDOG_NS    = 2_000_000;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [CHAN_W-1:0]     channel   = '0;
    logic [SAMPLE_W-1:0]   sample    = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [SAMPLE_W-1:0]   filtered;

    // test control
    logic                  steady_flow = 1'b0;
    logic                  rx_hold     = 1'b0;
    event                  hold_rx;

    // predictor state and expected results
    logic [SAMPLE_W-1:0]   chan_hist [CHAN_COUNT][HIST_LEN];
    logic [SAMPLE_W-1:0]   filtered_q [$];

    int                    err_count    = 0;
    int                    beats_sent   = 0;
    int                    results_seen = 0;

    multichannel_trimmed_mean_filter #(
        .CHANNELS    (CHAN_COUNT),
        .SAMPLE_BITS (SAMPLE_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .channel   (channel),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // mismatch reporting
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // window of four past samples plus the new one, trim one max and one min,
    // floor of the mean of the rest; then shift the sample into the history
    function automatic logic [SAMPLE_W-1:0] predict_filtered(
        input logic [CHAN_W-1:0]   ch,
        input logic [SAMPLE_W-1:0] s
    );
        logic [SAMPLE_W+2:0] total;
        logic [SAMPLE_W+2:0] mid_sum;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] v;
        total = (SAMPLE_W + 3)'(s);
        hi    = s;
        lo    = s;
        for (int i = 0; i < HIST_LEN; i++)
        begin
            v     = chan_hist[ch][i];
            total = total + (SAMPLE_W + 3)'(v);
            if (v > hi)
                hi = v;
            if (v < lo)
                lo = v;
        end
        mid_sum = total - (SAMPLE_W + 3)'(hi) - (SAMPLE_W + 3)'(lo);
        for (int i = 0; i < HIST_LEN - 1; i++)
            chan_hist[ch][i] = chan_hist[ch][i + 1];
        chan_hist[ch][HIST_LEN - 1] = s;
        return SAMPLE_W'(mid_sum / (SAMPLE_W + 3)'(MID_COUNT));
    endfunction

    // sample profiles: near zero, near full scale, or any value
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 4))
            0:       s = SAMPLE_W'($urandom_range(0, 3));
            1:       s = SAMPLE_MAX - SAMPLE_W'($urandom_range(0, 3));
            default: s = SAMPLE_W'($urandom());
        endcase
        return s;
    endfunction

    // send one input beat; handshake sampled at the falling edge, where
    // everything has settled, and taken at the following rising edge
    task automatic send_beat(
        input logic [CHAN_W-1:0]   ch,
        input logic [SAMPLE_W-1:0] s
    );
        logic taken;
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= s;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            if (taken)
                filtered_q.push_back(predict_filtered(ch, s));
            @(posedge clk);
        end
        beats_sent++;
    endtask

    // receiver side ready, with random idling and the hold-off
    always @(posedge clk)
    begin
        if (rx_hold)
            out_ready <= 1'b0;
        else if (steady_flow)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // long receiver hold-off, counted here
    initial
    begin
        forever
        begin
            @(hold_rx);
            rx_hold <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // result checking against the oldest expectation
    always @(negedge clk)
    begin
        logic [SAMPLE_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (filtered_q.size() == 0)
                report_mismatch($sformatf("result %0d with no expected beat, filtered=%0d",
                                          results_seen, filtered));
            else
            begin
                want = filtered_q.pop_front();
                if (filtered !== want)
                    report_mismatch($sformatf("result %0d filtered=%0d expected %0d",
                                              results_seen, filtered, want));
            end
            results_seen++;
        end
    end

    // extremes, exact sum, ties and mixed orders on every channel
    task automatic test_directed();
        // full scale everywhere: middle sum exceeds the sample width
        repeat (WIN_LEN) send_beat(CHAN_W'(0), SAMPLE_MAX);
        send_beat(CHAN_W'(0), '0);
        // ties on both the largest and the smallest value
        send_beat(CHAN_W'(1), SAMPLE_W'(100));
        send_beat(CHAN_W'(1), SAMPLE_W'(100));
        send_beat(CHAN_W'(1), SAMPLE_W'(5));
        send_beat(CHAN_W'(1), SAMPLE_W'(100));
        send_beat(CHAN_W'(1), SAMPLE_W'(5));
        // alternating extremes
        send_beat(CHAN_W'(2), SAMPLE_W'(1));
        send_beat(CHAN_W'(2), SAMPLE_MAX);
        send_beat(CHAN_W'(2), SAMPLE_W'(2));
        send_beat(CHAN_W'(2), SAMPLE_MAX - SAMPLE_W'(1));
        send_beat(CHAN_W'(2), SAMPLE_W'(3));
        // bit patterns
        send_beat(CHAN_W'(3), SAMPLE_W'(16'h8000));
        send_beat(CHAN_W'(3), SAMPLE_W'(16'h7fff));
        send_beat(CHAN_W'(3), SAMPLE_W'(16'haaaa));
        send_beat(CHAN_W'(3), SAMPLE_W'(16'h5555));
        send_beat(CHAN_W'(3), SAMPLE_MAX);
    endtask

    // no idling: bursts on one channel, then two channels alternating,
    // so the history row is read right after it was written
    task automatic test_back_to_back();
        steady_flow <= 1'b1;
        for (int c = 0; c < CHAN_COUNT; c++)
            repeat (BURST_BEATS) send_beat(CHAN_W'(c), pick_sample());
        for (int n = 0; n < ALT_BEATS; n++)
            send_beat(CHAN_W'(n % 2), pick_sample());
        steady_flow <= 1'b0;
    endtask

    // random channels with runs on the same channel, random idling
    task automatic test_random_mix();
        logic [CHAN_W-1:0] ch;
        ch = '0;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if ($urandom_range(0, 3) != 0)
                ch = CHAN_W'($urandom_range(0, CHAN_COUNT - 1));
            send_beat(ch, pick_sample());
        end
    endtask

    // receiver holds off while beats keep coming, so the pipeline fills
    task automatic test_output_backpressure();
        -> hold_rx;
        for (int n = 0; n < STALL_BEATS; n++)
            send_beat(CHAN_W'($urandom_range(0, CHAN_COUNT - 1)), pick_sample());
    endtask

    // main sequence
    initial
    begin
        int waited;
        for (int c = 0; c < CHAN_COUNT; c++)
            for (int i = 0; i < HIST_LEN; i++)
                chan_hist[c][i] = '0;

        // hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_back_to_back();
        test_random_mix();
        test_output_backpressure();
        in_valid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        waited = 0;
        while (filtered_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (filtered_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      filtered_q.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d beats over %0d channels; checked %0d filtered results",
                 beats_sent, CHAN_COUNT, results_seen);
        $display("covered extremes, ties, same-channel bursts, random idling, output hold-off");
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(WATCHDOG_NS);
        $display("timeout after %0d ns", WATCHDOG_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[multichannel_trimmed_mean_filter.f]
hw/rtl/mtmf_pkg.sv
hw/rtl/mtmf_hist_ram.sv
hw/rtl/mtmf_trim.sv
hw/rtl/mtmf_div3.sv
hw/rtl/multichannel_trimmed_mean_filter.sv
test/multichannel_trimmed_mean_filter_tb.sv
